// ===== rtl/addressable_led_strip_driver_defines.svh =====
// Assertion macros shared by the driver RTL.
`ifndef ADDRESSABLE_LED_STRIP_DRIVER_DEFINES_SVH
`define ADDRESSABLE_LED_STRIP_DRIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked while out of reset
`define ALSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every edge, reset included
`define ALSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ALSD_ASSERT(lbl, prop, msg)
`define ALSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/alsd_pkg.sv =====
package alsd_pkg;

  // Request operations
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SHOW  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_BUSY      = 2'd2
  } status_e;

  // Configuration register indexes
  localparam logic [1:0] REG_PIXEL_COUNT = 2'd0;
  localparam logic [1:0] REG_SHORT_TICKS = 2'd1;
  localparam logic [1:0] REG_LONG_TICKS  = 2'd2;

  localparam int unsigned CfgDataW  = 9;
  localparam int unsigned PixelBits = 24;

  localparam logic [5:0] SHORT_TICKS_RST = 6'd7;
  localparam logic [5:0] LONG_TICKS_RST  = 6'd18;

  // Stored pixel: green in the top byte, blue in the bottom one
  typedef logic [PixelBits-1:0] pixel_t;

  typedef struct packed {
    logic [8:0] pixel_count;
    logic [5:0] short_ticks;
    logic [5:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    logic    line_level;
    logic    busy_res;
    status_e status;
    logic    done_res;
  } result_t;

endpackage

// ===== rtl/alsd_intf.sv =====
// Request channel
interface alsd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output operation, output pixel_index, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input operation, input pixel_index, input red,
                  input green, input blue, output ready);
endinterface

// Result channel
interface alsd_res_if;
  logic       valid;
  logic       ready;
  logic       line_level;
  logic       busy_res;
  logic [1:0] status;
  logic       done_res;

  modport source (output valid, output line_level, output busy_res, output status,
                  output done_res, input ready);
  modport sink   (input valid, input line_level, input busy_res, input status,
                  input done_res, output ready);
endinterface

// ===== rtl/alsd_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle
module alsd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/alsd_seq.sv =====
// Waveform sequencer: command decode, bit timing and pixel store access
`include "addressable_led_strip_driver_defines.svh"

module alsd_seq #(
  parameter int unsigned MAX_PIXELS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [1:0]            op_i,
  input  logic [7:0]            idx_i,
  input  alsd_pkg::pixel_t      pixel_i,
  input  alsd_pkg::cfg_t        cfg_i,
  input  alsd_pkg::pixel_t      rd_data_i,
  output logic [(MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1)-1:0] rd_addr_o,
  output logic                  wr_en_o,
  output logic [(MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1)-1:0] wr_addr_o,
  output alsd_pkg::pixel_t      wr_data_o,
  output alsd_pkg::result_t     res_o
);

  localparam int unsigned AW   = MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned NW   = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CMPW = NW > 9 ? NW : 9;

  logic             sending_q, sending_d;
  logic             clearing_q, clearing_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [4:0]       bit_q, bit_d;
  logic             high_q, high_d;
  logic [5:0]       tc_q, tc_d;
  logic             pend_q, pend_d;
  alsd_pkg::pixel_t cur_word_q, cur_word_d;

  logic [CMPW-1:0]  count_ext;
  logic [NW-1:0]    in_use;
  logic [NW-1:0]    pos_inc;
  alsd_pkg::pixel_t word;
  logic             one;
  logic [5:0]       len_raw;
  logic [5:0]       len;
  logic [5:0]       tc_inc;
  logic             part_end;

  // Pixels in use, capped at the store depth
  assign count_ext = CMPW'(cfg_i.pixel_count);
  assign in_use    = (count_ext > CMPW'(MAX_PIXELS)) ? NW'(MAX_PIXELS) : NW'(count_ext);
  assign pos_inc   = NW'(pos_q) + NW'(1);

  // Current pixel comes straight from the RAM on the first cycle after a start
  assign word    = pend_q ? rd_data_i : cur_word_q;
  assign one     = !clearing_q && word[5'd23 - bit_q];
  assign len_raw = high_q ? (one ? cfg_i.long_ticks : cfg_i.short_ticks)
                          : (one ? cfg_i.short_ticks : cfg_i.long_ticks);
  assign len      = (len_raw == 6'd0) ? 6'd1 : len_raw;
  assign tc_inc   = tc_q + 6'd1;
  assign part_end = tc_inc >= len;

  // Prefetch the following pixel while one is on the line
  assign rd_addr_o = sending_q ? AW'(pos_inc) : '0;

  // Next state and result
  always_comb begin
    sending_d  = sending_q;
    clearing_d = clearing_q;
    pos_d      = pos_q;
    bit_d      = bit_q;
    high_d     = high_q;
    tc_d       = tc_q;
    pend_d     = 1'b0;
    cur_word_d = pend_q ? rd_data_i : cur_word_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = pos_q;
    wr_data_o  = '0;
    res_o.line_level = 1'b0;
    res_o.status     = alsd_pkg::ST_OK;
    res_o.done_res   = 1'b0;

    if (accept_i) begin
      case (alsd_pkg::op_e'(op_i))
        alsd_pkg::OP_TICK: begin
          if (sending_q) begin
            res_o.line_level = high_q;
            if (!part_end) begin
              tc_d = tc_inc;
            end else begin
              tc_d = '0;
              if (high_q) begin
                high_d = 1'b0;
              end else begin
                high_d = 1'b1;
                if (bit_q != 5'd23) begin
                  bit_d = bit_q + 5'd1;
                end else begin
                  bit_d = '0;
                  // zero the pixel once its bits are out
                  if (clearing_q) begin
                    wr_en_o   = 1'b1;
                    wr_addr_o = pos_q;
                    wr_data_o = '0;
                  end
                  if (pos_inc < in_use) begin
                    pos_d      = AW'(pos_inc);
                    cur_word_d = rd_data_i;
                  end else begin
                    pos_d          = '0;
                    sending_d      = 1'b0;
                    clearing_d     = 1'b0;
                    high_d         = 1'b0;
                    res_o.done_res = 1'b1;
                  end
                end
              end
            end
          end
        end
        alsd_pkg::OP_WRITE: begin
          if (sending_q) begin
            res_o.status     = alsd_pkg::ST_BUSY;
            res_o.line_level = high_q;
          end else if (CMPW'(idx_i) >= CMPW'(in_use)) begin
            res_o.status = alsd_pkg::ST_BAD_INDEX;
          end else begin
            wr_en_o   = 1'b1;
            wr_addr_o = AW'(idx_i);
            wr_data_o = pixel_i;
          end
        end
        alsd_pkg::OP_SHOW, alsd_pkg::OP_CLEAR: begin
          if (sending_q) begin
            res_o.status     = alsd_pkg::ST_BUSY;
            res_o.line_level = high_q;
          end else if (in_use != '0) begin
            sending_d  = 1'b1;
            clearing_d = (alsd_pkg::op_e'(op_i) == alsd_pkg::OP_CLEAR);
            pos_d      = '0;
            bit_d      = '0;
            high_d     = 1'b1;
            tc_d       = '0;
            pend_d     = 1'b1;
          end
        end
        default: ;
      endcase
    end
    res_o.busy_res = sending_d;
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q  <= 1'b0;
      clearing_q <= 1'b0;
      pos_q      <= '0;
      bit_q      <= '0;
      high_q     <= 1'b0;
      tc_q       <= '0;
      pend_q     <= 1'b0;
    end else begin
      sending_q  <= sending_d;
      clearing_q <= clearing_d;
      pos_q      <= pos_d;
      bit_q      <= bit_d;
      high_q     <= high_d;
      tc_q       <= tc_d;
      pend_q     <= pend_d;
    end
  end

  // Pixel word holding register
  always_ff @(posedge clk_i) begin
    cur_word_q <= cur_word_d;
  end

  `ALSD_ASSERT(a_bit_range, bit_q < 5'd24, "bit position out of range")
  `ALSD_ASSERT(a_tick_range, tc_q != 6'd63, "tick counter overrun")
  `ALSD_ASSERT(a_clear_in_send, clearing_q |-> sending_q, "clearing outside a transmission")
  `ALSD_ASSERT(a_start_fetch, $rose(sending_q) |-> pend_q, "start without pixel fetch")

endmodule

// ===== rtl/addressable_led_strip_driver.sv =====
// Addressable LED strip driver.
// Requests arrive on req_i: a tick advances the single-wire waveform by one
// tick period, a write stores one pixel, show sends pixels 0 .. pixel_count-1
// and clear sends zeros while blanking each pixel it passes. Every request
// gives exactly one result on res_o: line level for that tick, busy flag,
// status and an end-of-transmission flag.
// Throughput is one request per clock while results are taken and no sweep
// runs; the result is registered in the cycle after acceptance. The pixel
// store is a single RAM with a registered read; the next pixel is prefetched
// while the current one is on the line, and a pixel takes at least 48 ticks.
// The user writes configuration through cfg_we_i / cfg_idx_i / cfg_data_i
// only while no transmission is running; the block does not enforce this.
// After reset the store is swept to zero, one entry per cycle, over all
// MAX_PIXELS entries (256 by default); req_i.ready stays low during the sweep.
// When the receiver stalls, the result is held and req_i.ready drops until
// the result is taken.
`include "addressable_led_strip_driver_defines.svh"

module addressable_led_strip_driver #(
  parameter int unsigned MAX_PIXELS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alsd_req_if.sink    req_i,
  alsd_res_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [alsd_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW = MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1;

  alsd_pkg::cfg_t    cfg_q;
  alsd_pkg::result_t seq_res;
  alsd_pkg::result_t res_q;
  logic              res_valid_q;
  logic              accept;

  logic              sweep_busy_q;
  logic [AW-1:0]     sweep_addr_q;

  logic [AW-1:0]     rd_addr;
  alsd_pkg::pixel_t  rd_data;
  logic              seq_wr_en;
  logic [AW-1:0]     seq_wr_addr;
  alsd_pkg::pixel_t  seq_wr_data;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  alsd_pkg::pixel_t  ram_wdata;

  // Take a request after the sweep whenever the result register frees up
  assign req_i.ready = !sweep_busy_q && (!res_valid_q || res_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_count <= '0;
      cfg_q.short_ticks <= alsd_pkg::SHORT_TICKS_RST;
      cfg_q.long_ticks  <= alsd_pkg::LONG_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        alsd_pkg::REG_PIXEL_COUNT: cfg_q.pixel_count <= cfg_data_i;
        alsd_pkg::REG_SHORT_TICKS: cfg_q.short_ticks <= cfg_data_i[5:0];
        alsd_pkg::REG_LONG_TICKS:  cfg_q.long_ticks  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Zeroing sweep over the store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_busy_q <= 1'b1;
      sweep_addr_q <= '0;
    end else if (sweep_busy_q) begin
      sweep_addr_q <= sweep_addr_q + AW'(1);
      if (sweep_addr_q == AW'(MAX_PIXELS - 1)) begin
        sweep_busy_q <= 1'b0;
      end
    end
  end

  alsd_seq #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (req_i.operation),
    .idx_i     (req_i.pixel_index),
    .pixel_i   ({req_i.green, req_i.red, req_i.blue}),
    .cfg_i     (cfg_q),
    .rd_data_i (rd_data),
    .rd_addr_o (rd_addr),
    .wr_en_o   (seq_wr_en),
    .wr_addr_o (seq_wr_addr),
    .wr_data_o (seq_wr_data),
    .res_o     (seq_res)
  );

  // Store write port: sweep has it until it finishes
  assign ram_we    = sweep_busy_q || seq_wr_en;
  assign ram_waddr = sweep_busy_q ? sweep_addr_q : seq_wr_addr;
  assign ram_wdata = sweep_busy_q ? '0 : seq_wr_data;

  alsd_ram #(
    .WIDTH (alsd_pkg::PixelBits),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= seq_res;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.line_level = res_q.line_level;
  assign res_o.busy_res   = res_q.busy_res;
  assign res_o.status     = res_q.status;
  assign res_o.done_res   = res_q.done_res;

  `ALSD_ASSERT(a_sweep_full, $fell(sweep_busy_q) |-> $past(sweep_addr_q) == AW'(MAX_PIXELS - 1), "sweep ended early")
  `ALSD_ASSERT(a_no_req_in_sweep, sweep_busy_q |-> !accept && !seq_wr_en, "store access during sweep")
  `ALSD_ASSERT(a_res_after_req, $past(accept) |-> res_valid_q, "accepted request lost its result")

endmodule

// ===== test/tb_top.sv =====
module tb_top;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TARGET_REQUESTS = 1400;

  // One request as seen on the request channel
  typedef struct packed {
    alsd_pkg::op_e op;
    logic [7:0]    index;
    logic [7:0]    red;
    logic [7:0]    green;
    logic [7:0]    blue;
  } led_req_t;

  // Waveform predictor plus the queue of results it still owes
  class led_strip_scoreboard;
    bit [23:0]         pixels [256];
    bit [8:0]          pixel_count;
    bit [5:0]          short_ticks;
    bit [5:0]          long_ticks;
    bit                sending;
    bit                clearing;
    bit [8:0]          pixel_pos;
    bit [4:0]          bit_pos;
    bit                in_high;
    bit [5:0]          tick_count;
    alsd_pkg::result_t awaited [$];
    int                n_writes;
    int                n_shows;
    int                n_clears;
    int                n_ticks;
    int                n_checked;
    int                errors;

    function new();
      short_ticks = alsd_pkg::SHORT_TICKS_RST;
      long_ticks  = alsd_pkg::LONG_TICKS_RST;
    endfunction

    function void write_register(logic [1:0] idx, logic [8:0] value);
      case (idx)
        alsd_pkg::REG_PIXEL_COUNT: pixel_count = value;
        alsd_pkg::REG_SHORT_TICKS: short_ticks = value[5:0];
        alsd_pkg::REG_LONG_TICKS:  long_ticks  = value[5:0];
        default: ;
      endcase
    endfunction

    // Pixel counts beyond the store saturate
    function bit [8:0] in_use();
      return (pixel_count > 9'd256) ? 9'd256 : pixel_count;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Data bit currently on the line; clearing always sends zeros
    function bit line_bit();
      if (clearing) return 1'b0;
      return pixels[pixel_pos[7:0]][alsd_pkg::PixelBits - 1 - bit_pos];
    endfunction

    // Advance the waveform by one tick; returns 1 when the last bit ends
    function bit advance_tick();
      bit       one;
      bit [5:0] part_len;
      one = line_bit();
      if (in_high) part_len = one ? long_ticks : short_ticks;
      else part_len = one ? short_ticks : long_ticks;
      if (part_len == 0) part_len = 1;
      tick_count = tick_count + 1'b1;
      if (tick_count < part_len) return 1'b0;
      tick_count = '0;
      if (in_high) begin
        in_high = 1'b0;
        return 1'b0;
      end
      in_high = 1'b1;
      bit_pos = bit_pos + 1'b1;
      if (bit_pos < alsd_pkg::PixelBits) return 1'b0;
      bit_pos = '0;
      if (clearing) pixels[pixel_pos[7:0]] = '0;
      pixel_pos = pixel_pos + 1'b1;
      if (pixel_pos < in_use()) return 1'b0;
      pixel_pos = '0;
      sending   = 1'b0;
      clearing  = 1'b0;
      in_high   = 1'b0;
      return 1'b1;
    endfunction

    function void note_request(led_req_t rq);
      alsd_pkg::result_t exp;
      exp = '0;
      case (rq.op)
        alsd_pkg::OP_WRITE: n_writes++;
        alsd_pkg::OP_SHOW:  n_shows++;
        alsd_pkg::OP_CLEAR: n_clears++;
        default:            n_ticks++;
      endcase
      if (rq.op == alsd_pkg::OP_TICK) begin
        if (sending) begin
          exp.line_level = in_high;
          exp.done_res   = advance_tick();
        end
      end else if (sending) begin
        // commands bounce while the line is busy; the level is held
        exp.status     = alsd_pkg::ST_BUSY;
        exp.line_level = in_high;
      end else if (rq.op == alsd_pkg::OP_WRITE) begin
        if ({1'b0, rq.index} >= in_use()) exp.status = alsd_pkg::ST_BAD_INDEX;
        else pixels[rq.index] = {rq.green, rq.red, rq.blue};
      end else if (in_use() != 0) begin
        sending    = 1'b1;
        clearing   = (rq.op == alsd_pkg::OP_CLEAR);
        pixel_pos  = '0;
        bit_pos    = '0;
        in_high    = 1'b1;
        tick_count = '0;
      end
      exp.busy_res = sending;
      awaited.push_back(exp);
    endfunction

    function void compare_field(string name, logic [1:0] want, logic [1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(alsd_pkg::result_t got);
      alsd_pkg::result_t exp;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      exp = awaited.pop_front();
      n_checked++;
      compare_field("line_level", 2'(exp.line_level), 2'(got.line_level));
      compare_field("busy_res", 2'(exp.busy_res), 2'(got.busy_res));
      compare_field("status", 2'(exp.status), 2'(got.status));
      compare_field("done_res", 2'(exp.done_res), 2'(got.done_res));
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [1:0]                    cfg_idx;
  logic [alsd_pkg::CfgDataW-1:0] cfg_data;
  bit                            gaps_on;
  int                            hold_left = 0;
  int                            requests_taken = 0;
  led_strip_scoreboard           sb;

  alsd_req_if req_if ();
  alsd_res_if res_if ();

  addressable_led_strip_driver DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample both channels on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_request('{op: alsd_pkg::op_e'(req_if.operation), index: req_if.pixel_index,
                          red: req_if.red, green: req_if.green, blue: req_if.blue});
        requests_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        sb.check_result('{line_level: res_if.line_level, busy_res: res_if.busy_res,
                          status: alsd_pkg::status_e'(res_if.status),
                          done_res: res_if.done_res});
      end
    end
  end

  // Result back-pressure in random bursts
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 23) == 0) begin
      hold_left <= $urandom_range(0, 18);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Give up once nothing moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("[addressable_led_strip_driver] ERROR");
    $finish;
  end

  // Present one request and hold it until taken; valid stays high afterwards
  task automatic put_request(input alsd_pkg::op_e op, input logic [7:0] idx,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
    int seen;
    if (gaps_on && $urandom_range(0, 23) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.pixel_index <= idx;
    req_if.red         <= r;
    req_if.green       <= g;
    req_if.blue        <= b;
    seen = requests_taken;
    do @(negedge clk); while (requests_taken == seen);
  endtask

  task automatic put_tick();
    put_request(alsd_pkg::OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Tick until the transmission in flight has finished
  task automatic run_out();
    while (sb.sending) put_tick();
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(input logic [1:0] idx,
                              input logic [alsd_pkg::CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    sb.write_register(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [8:0] count, input logic [5:0] s, input logic [5:0] l);
    settle();
    set_register(alsd_pkg::REG_PIXEL_COUNT, count);
    set_register(alsd_pkg::REG_SHORT_TICKS, 9'(s));
    set_register(alsd_pkg::REG_LONG_TICKS, 9'(l));
  endtask

  // Mostly ticks while sending, mostly writes while idle
  task automatic random_step();
    int            pick;
    alsd_pkg::op_e op;
    logic [7:0]    idx;
    pick = $urandom_range(0, 99);
    idx  = 8'($urandom_range(0, 255));
    if (sb.sending) begin
      op = (pick < 90) ? alsd_pkg::OP_TICK : alsd_pkg::op_e'(2'($urandom_range(1, 3)));
    end else if (pick < 55) begin
      op = alsd_pkg::OP_WRITE;
      if (sb.in_use() != 0 && $urandom_range(0, 4) != 0) begin
        idx = 8'($urandom_range(0, sb.in_use() - 1));
      end
    end else if (pick < 70) begin
      op = alsd_pkg::OP_SHOW;
    end else if (pick < 80) begin
      op = alsd_pkg::OP_CLEAR;
    end else begin
      op = alsd_pkg::OP_TICK;
    end
    put_request(op, idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
  endtask

  // Short strips and short pulses keep each transmission to a few hundred ticks
  task automatic random_phase();
    int         pick;
    logic [8:0] count;
    logic [5:0] s;
    logic [5:0] l;
    pick = $urandom_range(0, 99);
    if (pick < 10) count = '0;
    else count = 9'($urandom_range(1, 3));
    if (count == 9'd3) begin
      s = 6'($urandom_range(0, 1));
      l = 6'($urandom_range(0, 1));
    end else if ($urandom_range(0, 4) == 0) begin
      count = 9'd1;
      s = 6'($urandom_range(0, 6));
      l = 6'($urandom_range(0, 6));
    end else begin
      s = 6'($urandom_range(0, 2));
      l = 6'($urandom_range(0, 2));
    end
    configure(count, s, l);
    repeat ($urandom_range(10, 20)) random_step();
    run_out();
  endtask

  initial begin
    sb = new();
    gaps_on            = 1'b1;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = alsd_pkg::REG_PIXEL_COUNT;
    cfg_data           = '0;
    req_if.valid       = 1'b0;
    req_if.operation   = alsd_pkg::OP_TICK;
    req_if.pixel_index = '0;
    req_if.red         = '0;
    req_if.green       = '0;
    req_if.blue        = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Empty strip: idle tick, write out of range, show and clear do nothing
    put_request(alsd_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    put_request(alsd_pkg::OP_WRITE, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    put_request(alsd_pkg::OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    put_request(alsd_pkg::OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);

    // One pixel with the pulse lengths left at their reset values
    settle();
    set_register(alsd_pkg::REG_PIXEL_COUNT, 9'd1);
    put_request(alsd_pkg::OP_WRITE, 8'd0, 8'h00, 8'hFF, 8'hA5);
    put_request(alsd_pkg::OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    run_out();

    // Two pixels with short pulses, bounced commands, then clear and re-show
    configure(9'd2, 6'd1, 6'd1);
    put_request(alsd_pkg::OP_WRITE, 8'd0, 8'h00, 8'hFF, 8'hA5);
    put_request(alsd_pkg::OP_WRITE, 8'd1, 8'hFF, 8'h00, 8'h5A);
    put_request(alsd_pkg::OP_WRITE, 8'd2, 8'h12, 8'h34, 8'h56);
    put_request(alsd_pkg::OP_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    put_request(alsd_pkg::OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    put_request(alsd_pkg::OP_WRITE, 8'd0, 8'h11, 8'h22, 8'h33);
    put_request(alsd_pkg::OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    put_request(alsd_pkg::OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
    run_out();
    put_request(alsd_pkg::OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
    run_out();
    put_request(alsd_pkg::OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    run_out();

    // Zero pulse lengths behave as one tick
    configure(9'd1, 6'd0, 6'd0);
    put_request(alsd_pkg::OP_WRITE, 8'd0, 8'hC3, 8'h3C, 8'h81);
    put_request(alsd_pkg::OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    run_out();

    // Oversized pixel count saturates at the store depth for writes
    configure(9'd511, 6'd1, 6'd1);
    put_request(alsd_pkg::OP_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    put_request(alsd_pkg::OP_WRITE, 8'd0, 8'h7E, 8'hE7, 8'h01);
    configure(9'd255, 6'd1, 6'd1);
    put_request(alsd_pkg::OP_WRITE, 8'd255, 8'h01, 8'h02, 8'h03);
    put_request(alsd_pkg::OP_WRITE, 8'd254, 8'h04, 8'h05, 8'h06);

    // Random phases; the tail runs without any idling
    while (requests_taken < TARGET_REQUESTS) begin
      if (requests_taken > TARGET_REQUESTS * 85 / 100) gaps_on = 1'b0;
      random_phase();
    end

    settle();
    repeat (16) @(negedge clk);
    $display("Sent %0d requests: %0d writes, %0d shows, %0d clears, %0d ticks",
             requests_taken, sb.n_writes, sb.n_shows, sb.n_clears, sb.n_ticks);
    $display("Checked %0d results, %0d mismatches, %0d still outstanding",
             sb.n_checked, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[addressable_led_strip_driver] OK");
    end else begin
      $display("[addressable_led_strip_driver] ERROR");
    end
    $finish;
  end

endmodule
